// ----- src/psg_tone_noise_generator_unit_assert.svh -----
// assertion macros used by the checker of the sound generator
`ifndef PSG_TONE_NOISE_GENERATOR_UNIT_ASSERT_SVH
`define PSG_TONE_NOISE_GENERATOR_UNIT_ASSERT_SVH

// same-cycle implication, masked during reset
`define PSG_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, masked during reset
`define PSG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// next-cycle implication that also watches reset itself
`define PSG_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- src/psgtn_pkg.sv -----
package psgtn_pkg;

  localparam int PERIOD_W = 10;
  localparam int ATT_W    = 4;
  localparam int LEVEL_W  = 7;

  localparam logic [15:0]         NOISE_SEED  = 16'h8000;
  localparam logic [ATT_W-1:0]    ATT_SILENT  = 4'hF;
  localparam logic [1:0]          CH_NOISE    = 2'd3;
  localparam logic                OP_WRITE    = 1'b0;

  localparam logic [1:0] RATE_16   = 2'd0;
  localparam logic [1:0] RATE_32   = 2'd1;
  localparam logic [1:0] RATE_64   = 2'd2;
  localparam logic [1:0] RATE_TONE = 2'd3;

  // next-state view of one counter channel, used by the mixer
  typedef struct packed {
    logic active;
    logic sign;
  } tone_stat_t;

  function automatic logic [PERIOD_W-1:0] noise_reload(input logic [1:0] rate,
                                                       input logic [PERIOD_W-1:0] tone2);
    logic [PERIOD_W-1:0] v;
    unique case (rate)
      RATE_16:   v = PERIOD_W'(16'h0010);
      RATE_32:   v = PERIOD_W'(16'h0020);
      RATE_64:   v = PERIOD_W'(16'h0040);
      RATE_TONE: v = tone2;
      default:   v = tone2;
    endcase
    return v;
  endfunction

endpackage

// ----- src/psgtn_tone.sv -----
module psgtn_tone (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             tick_en,
  input  logic [psgtn_pkg::PERIOD_W-1:0]   period,
  output psgtn_pkg::tone_stat_t            stat_nxt
);

  logic [psgtn_pkg::PERIOD_W-1:0] cnt_r, cnt_nxt;
  logic                           sign_r, sign_nxt;

  always_comb begin
    cnt_nxt  = cnt_r;
    sign_nxt = sign_r;
    if (tick_en) begin
      if (cnt_r != '0) begin
        cnt_nxt = cnt_r - 1'b1;
      end else begin
        cnt_nxt  = period;
        sign_nxt = ~sign_r;
      end
    end
  end

  assign stat_nxt.active = (cnt_nxt != '0);
  assign stat_nxt.sign   = sign_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      sign_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      sign_r <= sign_nxt;
    end
  end

endmodule

// ----- src/psg_tone_noise_generator_unit.sv -----
// three-tone, one-noise sound generator
// input channel: in_valid / in_stall with in_op (0 = register write byte,
//   1 = one chip clock tick) and in_data_byte (ignored on a tick)
// output channel: out_valid / out_stall with out_sample_level, the signed mix
//   after the item in units of 1/60 full scale (range -45 to 60)
// every input item gives exactly one output item, in order
// an accepted item passes the input register, then state update and mix into
//   the output register
// throughput: one item per cycle when not stalled; all channel counters,
//   the noise shift register and the four-term mix update in one state stage
// a stalled output holds its item; the stage behind it keeps one more item
//   in the input register and in_stall rises only when both are full
// synchronous reset: all channels silent (attenuation 15), periods and
//   counters zero, signs positive, noise shift register at its seed,
//   both stages empty
module psg_tone_noise_generator_unit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_op,
  input  logic [7:0]                            in_data_byte,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [psgtn_pkg::LEVEL_W-1:0]  out_sample_level
);

  localparam int PW = psgtn_pkg::PERIOD_W;
  localparam int AW = psgtn_pkg::ATT_W;
  localparam int LW = psgtn_pkg::LEVEL_W;

  // input stage
  logic       v1_r;
  logic       op1_r;
  logic [7:0] byte1_r;
  logic       adv;

  assign adv      = v1_r && (!out_valid || !out_stall);
  assign in_stall = v1_r && !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (!in_stall) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      op1_r   <= in_op;
      byte1_r <= in_data_byte;
    end
  end

  // architectural state
  logic [AW-1:0] att_r    [4];
  logic [AW-1:0] att_nxt  [4];
  logic [PW-1:0] period_r [3];
  logic [PW-1:0] period_nxt [3];
  logic [2:0]    nctl_r, nctl_nxt;
  logic [1:0]    lat_ch_r, lat_ch_nxt;
  logic          lat_vol_r, lat_vol_nxt;
  logic [PW-1:0] ncnt_r, ncnt_nxt;
  logic          nsign_r, nsign_nxt;
  logic [15:0]   nshift_r, nshift_nxt;
  logic          nbit_r, nbit_nxt;

  logic is_write, is_tick;
  assign is_write = adv && (op1_r == psgtn_pkg::OP_WRITE);
  assign is_tick  = adv && (op1_r != psgtn_pkg::OP_WRITE);

  // register write decode
  always_comb begin
    for (int i = 0; i < 4; i++) att_nxt[i] = att_r[i];
    for (int i = 0; i < 3; i++) period_nxt[i] = period_r[i];
    nctl_nxt    = nctl_r;
    lat_ch_nxt  = lat_ch_r;
    lat_vol_nxt = lat_vol_r;
    if (is_write) begin
      if (byte1_r[7]) begin
        lat_ch_nxt  = byte1_r[6:5];
        lat_vol_nxt = byte1_r[4];
      end
      if (lat_vol_nxt) begin
        att_nxt[lat_ch_nxt] = byte1_r[3:0];
      end else if (lat_ch_nxt == psgtn_pkg::CH_NOISE) begin
        nctl_nxt = byte1_r[2:0];
      end else if (byte1_r[7]) begin
        period_nxt[lat_ch_nxt[1:0]][3:0] = byte1_r[3:0];
      end else begin
        period_nxt[lat_ch_nxt[1:0]][9:4] = byte1_r[5:0];
      end
    end
  end

  logic noise_ctl_wr;
  assign noise_ctl_wr = is_write && !lat_vol_nxt && (lat_ch_nxt == psgtn_pkg::CH_NOISE);

  // tone channels
  psgtn_pkg::tone_stat_t tstat [3];

  for (genvar g = 0; g < 3; g++) begin : g_tone
    psgtn_tone u_tone (
      .clk      (clk),
      .rst_n    (rst_n),
      .tick_en  (is_tick),
      .period   (period_r[g]),
      .stat_nxt (tstat[g])
    );
  end

  // noise channel: shift on every second reload
  always_comb begin
    ncnt_nxt   = ncnt_r;
    nsign_nxt  = nsign_r;
    nshift_nxt = nshift_r;
    nbit_nxt   = nbit_r;
    if (noise_ctl_wr) begin
      nshift_nxt = psgtn_pkg::NOISE_SEED;
    end
    if (is_tick) begin
      if (ncnt_r != '0) begin
        ncnt_nxt = ncnt_r - 1'b1;
      end else begin
        ncnt_nxt  = psgtn_pkg::noise_reload(nctl_r[1:0], period_r[2]);
        nsign_nxt = ~nsign_r;
        if (nsign_r) begin
          nbit_nxt   = nshift_r[0];
          nshift_nxt = {(nctl_r[2] ? (nshift_r[0] ^ nshift_r[3]) : nshift_r[0]),
                        nshift_r[15:1]};
        end
      end
    end
  end

  // mix of the state after this item
  logic signed [LW-1:0] mix;
  always_comb begin
    logic signed [LW-1:0] amp;
    mix = '0;
    for (int i = 0; i < 3; i++) begin
      amp = $signed({{(LW-AW){1'b0}}, ~att_nxt[i]});
      if (tstat[i].active) begin
        mix = tstat[i].sign ? (mix - amp) : (mix + amp);
      end
    end
    amp = $signed({{(LW-AW){1'b0}}, ~att_nxt[3]});
    if ((ncnt_nxt != '0) && nbit_nxt) begin
      mix = mix + amp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) att_r[i] <= psgtn_pkg::ATT_SILENT;
      for (int i = 0; i < 3; i++) period_r[i] <= '0;
      nctl_r    <= '0;
      lat_ch_r  <= '0;
      lat_vol_r <= 1'b0;
      ncnt_r    <= '0;
      nsign_r   <= 1'b0;
      nshift_r  <= psgtn_pkg::NOISE_SEED;
      nbit_r    <= 1'b0;
    end else begin
      for (int i = 0; i < 4; i++) att_r[i] <= att_nxt[i];
      for (int i = 0; i < 3; i++) period_r[i] <= period_nxt[i];
      nctl_r    <= nctl_nxt;
      lat_ch_r  <= lat_ch_nxt;
      lat_vol_r <= lat_vol_nxt;
      ncnt_r    <= ncnt_nxt;
      nsign_r   <= nsign_nxt;
      nshift_r  <= nshift_nxt;
      nbit_r    <= nbit_nxt;
    end
  end

  // output register
  logic                 out_valid_r;
  logic signed [LW-1:0] level_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      level_r <= mix;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sample_level = level_r;

endmodule

// ----- src/psgtn_checker.sv -----
`include "psg_tone_noise_generator_unit_assert.svh"

module psgtn_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_stall,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic signed [psgtn_pkg::LEVEL_W-1:0] out_sample_level
);

  // a held output item keeps its level
  `PSG_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_sample_level))

  // the mix never leaves its range
  `PSG_ASSERT_NOW(a_level_range, out_valid, ($signed(out_sample_level) >= -45) && ($signed(out_sample_level) <= 60))

  // with the output side empty the input side is never held off
  `PSG_ASSERT_NOW(a_no_stall_empty, !out_valid, !in_stall)

  // reset empties the pipeline
  `PSG_ASSERT_RST(a_reset_empty, !rst_n, !out_valid && !in_stall)

  // an item taken into an empty, unstalled block passes both registers to out_valid
  `PSG_ASSERT_NEXT(a_latency, in_valid && !in_stall && !out_valid && !out_stall, ##1 out_valid)

endmodule

bind psg_tone_noise_generator_unit psgtn_checker u_psgtn_checker (.*);

// ----- test/tb_psg_tone_noise_generator_unit.sv -----
module tb_psg_tone_noise_generator_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import psgtn_pkg::*;

  localparam logic       OP_TICK   = 1'b1;
  localparam logic [1:0] CH_TONE0  = 2'd0;
  localparam logic [1:0] CH_TONE1  = 2'd1;
  localparam logic [1:0] CH_TONE2  = 2'd2;
  localparam logic       SEL_TONE  = 1'b0;
  localparam logic       SEL_VOL   = 1'b1;
  localparam logic       NOISE_WHITE = 1'b1;
  localparam int         HOLD_CYCLES = 80;
  localparam int         QUIET_LIMIT = 3000;
  localparam int         SHOW_MAX    = 10;

  typedef logic signed [LEVEL_W-1:0] level_t;

  typedef struct {
    bit     known;
    level_t level;
  } level_hint_t;

  typedef struct {
    logic       op;
    logic [7:0] wbyte;
    bit         known;
    level_t     level;
  } dir_row_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic       in_op;
  logic [7:0] in_data_byte;
  logic       out_valid;
  logic       out_stall;
  level_t     out_sample_level;

  // mirror of the generator state
  logic [15:0]         chan_reg [4];
  logic [PERIOD_W-1:0] chan_cnt [4];
  logic                chan_neg [4];
  logic [15:0]         lfsr;
  logic                noise_on;
  logic [1:0]          sel_ch;
  logic                sel_vol;

  level_hint_t hand_levels[$];
  level_t      level_q[$];
  int          errors = 0;
  int          quiet = 0;
  int          n_writes = 0;
  int          n_ticks = 0;
  int          n_levels = 0;
  int          lo_level = 0;
  int          hi_level = 0;
  bit          send_gaps = 1'b0;
  bit          recv_gaps = 1'b0;
  bit          hold_req = 1'b0;

  psg_tone_noise_generator_unit u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sample_level (out_sample_level)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [7:0] latch_byte(input logic [1:0] ch, input logic vol,
                                            input logic [3:0] low);
    return {1'b1, ch, vol, low};
  endfunction

  function automatic logic [7:0] tail_byte(input logic [6:0] bits);
    return {1'b0, bits};
  endfunction

  function automatic void gen_reset();
    for (int i = 0; i < 4; i++) begin
      chan_reg[i] = {ATT_SILENT, 12'h000};
      chan_cnt[i] = '0;
      chan_neg[i] = 1'b0;
    end
    lfsr     = NOISE_SEED;
    noise_on = 1'b0;
    sel_ch   = CH_TONE0;
    sel_vol  = SEL_TONE;
  endfunction

  // applies one item to the mirror and returns the mix that follows it
  function automatic level_t gen_step(input logic op, input logic [7:0] b);
    logic [15:0] r;
    logic        fb;
    int          sum;
    int          amp;
    if (op == OP_WRITE) begin
      if (b[7]) begin
        sel_ch  = b[6:5];
        sel_vol = b[4];
      end
      r = chan_reg[sel_ch];
      if (sel_vol) begin
        r[15:12] = b[3:0];
      end else if (sel_ch == CH_NOISE) begin
        lfsr = NOISE_SEED;
        r    = {r[15:12], 9'd0, b[2:0]};
      end else if (b[7]) begin
        r[3:0] = b[3:0];
      end else begin
        r[9:4] = b[5:0];
      end
      r[11:10] = 2'b00;
      chan_reg[sel_ch] = r;
    end else begin
      for (int i = 0; i < 3; i++) begin
        if (chan_cnt[i] != 0) begin
          chan_cnt[i] = chan_cnt[i] - 1'b1;
        end else begin
          chan_cnt[i] = chan_reg[i][PERIOD_W-1:0];
          chan_neg[i] = ~chan_neg[i];
        end
      end
      if (chan_cnt[3] != 0) begin
        chan_cnt[3] = chan_cnt[3] - 1'b1;
      end else begin
        case (chan_reg[3][1:0])
          RATE_16: chan_cnt[3] = 10'h010;
          RATE_32: chan_cnt[3] = 10'h020;
          RATE_64: chan_cnt[3] = 10'h040;
          default: chan_cnt[3] = chan_reg[2][PERIOD_W-1:0];
        endcase
        chan_neg[3] = ~chan_neg[3];
        // noise shifts on every second reload
        if (!chan_neg[3]) begin
          noise_on = lfsr[0];
          fb       = chan_reg[3][2] ? (lfsr[0] ^ lfsr[3]) : lfsr[0];
          lfsr     = {fb, lfsr[15:1]};
        end
      end
    end
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      if (chan_cnt[i] != 0) begin
        amp = 15 - int'(chan_reg[i][15:12]);
        sum += chan_neg[i] ? -amp : amp;
      end
    end
    if (chan_cnt[3] != 0 && noise_on)
      sum += 15 - int'(chan_reg[3][15:12]);
    return LEVEL_W'(sum);
  endfunction

  task automatic offer(input logic op, input logic [7:0] b, input bit known,
                       input level_t level);
    if (send_gaps && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    hand_levels.push_back('{known, level});
    in_valid     <= 1'b1;
    in_op        <= op;
    in_data_byte <= b;
    do @(posedge clk); while (in_stall);
  endtask

  // mostly ticks, with tone periods biased small and noise resets kept rare
  task automatic pick_item(output logic op, output logic [7:0] b);
    logic [1:0] ch;
    logic       vol;
    logic [6:0] bits;
    ch   = 2'($urandom_range(0, 3));
    vol  = 1'($urandom);
    bits = 7'($urandom);
    b    = 8'($urandom);
    op   = ($urandom_range(0, 99) < 62) ? OP_TICK : OP_WRITE;
    if (op == OP_WRITE) begin
      if ($urandom_range(0, 9) < 6) begin
        if (ch == CH_NOISE && vol == SEL_TONE && $urandom_range(0, 3) != 0)
          vol = SEL_VOL;
        b = latch_byte(ch, vol, bits[3:0]);
      end else begin
        if ($urandom_range(0, 1) == 0)
          bits[5:1] = '0;
        b = tail_byte(bits);
      end
    end
  endtask

  task automatic run_random(input int count);
    logic       op;
    logic [7:0] b;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        send_gaps = ($urandom_range(0, 2) != 0);
        recv_gaps = ($urandom_range(0, 2) != 0);
      end
      pick_item(op, b);
      offer(op, b, 1'b0, '0);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (level_q.size() != 0) @(posedge clk);
  endtask

  // receiver side
  initial begin
    out_stall <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
        @(posedge clk);
      end else if (recv_gaps && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : monitor
    level_hint_t hint;
    level_t      level;
    level_t      want;
    if (rst_n) begin
      quiet++;
      if (in_valid && !in_stall) begin
        quiet = 0;
        hint  = hand_levels.pop_front();
        level = gen_step(in_op, in_data_byte);
        if (hint.known)
          level = hint.level;
        level_q.push_back(level);
        if (in_op == OP_WRITE)
          n_writes++;
        else
          n_ticks++;
      end
      if (out_valid && !out_stall) begin
        quiet = 0;
        n_levels++;
        if (int'(out_sample_level) < lo_level) lo_level = int'(out_sample_level);
        if (int'(out_sample_level) > hi_level) hi_level = int'(out_sample_level);
        if (level_q.size() == 0) begin
          errors++;
          if (errors <= SHOW_MAX)
            $display("%0t: level %0d with no item pending", $realtime,
                     out_sample_level);
        end else begin
          want = level_q.pop_front();
          if (out_sample_level !== want) begin
            errors++;
            if (errors <= SHOW_MAX)
              $display("%0t: level mismatch, expected %0d got %0d", $realtime,
                       want, out_sample_level);
          end
        end
      end
      if (quiet >= QUIET_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin : stimulus
    dir_row_t rows[$];
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_op        <= OP_WRITE;
    in_data_byte <= '0;
    gen_reset();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // silent after reset, tick ignores its data byte
    rows.push_back('{OP_TICK, 8'hFF, 1'b1, 7'sd0});
    // three tones at period one and full volume; counters still zero
    rows.push_back('{OP_WRITE, latch_byte(CH_TONE0, SEL_TONE, 4'h1), 1'b1, 7'sd0});
    rows.push_back('{OP_WRITE, latch_byte(CH_TONE0, SEL_VOL, 4'h0), 1'b1, 7'sd0});
    rows.push_back('{OP_WRITE, latch_byte(CH_TONE1, SEL_TONE, 4'h1), 1'b1, 7'sd0});
    rows.push_back('{OP_WRITE, latch_byte(CH_TONE1, SEL_VOL, 4'h0), 1'b1, 7'sd0});
    rows.push_back('{OP_WRITE, latch_byte(CH_TONE2, SEL_TONE, 4'h1), 1'b1, 7'sd0});
    rows.push_back('{OP_WRITE, latch_byte(CH_TONE2, SEL_VOL, 4'h0), 1'b1, 7'sd0});
    // reload flips all three positive, then counters hit zero, then negative
    rows.push_back('{OP_TICK, 8'h00, 1'b1, 7'sd45});
    rows.push_back('{OP_TICK, 8'h00, 1'b1, 7'sd0});
    rows.push_back('{OP_TICK, 8'h5A, 1'b1, -7'sd45});
    // noise at full volume, white, rate from tone two
    rows.push_back('{OP_WRITE, latch_byte(CH_NOISE, SEL_VOL, 4'h0), 1'b0, '0});
    rows.push_back('{OP_WRITE, latch_byte(CH_NOISE, SEL_TONE, {1'b0, NOISE_WHITE, RATE_TONE}),
                     1'b0, '0});
    // data byte into noise control reseeds the shift register
    rows.push_back('{OP_WRITE, tail_byte(7'h7F), 1'b0, '0});
    for (int i = 0; i < 6; i++)
      rows.push_back('{OP_TICK, 8'(i * 37), 1'b0, '0});
    // largest period on tone zero
    rows.push_back('{OP_WRITE, latch_byte(CH_TONE0, SEL_TONE, 4'hF), 1'b0, '0});
    rows.push_back('{OP_WRITE, tail_byte(7'h3F), 1'b0, '0});
    // volume through a data byte
    rows.push_back('{OP_WRITE, latch_byte(CH_TONE1, SEL_VOL, 4'hF), 1'b0, '0});
    rows.push_back('{OP_WRITE, tail_byte(7'h40), 1'b0, '0});
    // period zero on tone two
    rows.push_back('{OP_WRITE, latch_byte(CH_TONE2, SEL_TONE, 4'h0), 1'b0, '0});
    rows.push_back('{OP_WRITE, tail_byte(7'h00), 1'b0, '0});
    rows.push_back('{OP_TICK, 8'hFF, 1'b0, '0});
    rows.push_back('{OP_TICK, 8'h00, 1'b0, '0});
    foreach (rows[i])
      offer(rows[i].op, rows[i].wbyte, rows[i].known, rows[i].level);

    run_random(300);

    // receiver holds off while items keep coming, so the input backs up
    send_gaps = 1'b0;
    hold_req  = 1'b1;
    run_random_burst: for (int i = 0; i < 40; i++) begin
      logic       op;
      logic [7:0] b;
      pick_item(op, b);
      offer(op, b, 1'b0, '0);
    end
    drain();

    run_random(250);

    // closing stretch with no idling on either side
    send_gaps = 1'b0;
    recv_gaps = 1'b0;
    for (int i = 0; i < 80; i++) begin
      logic       op;
      logic [7:0] b;
      pick_item(op, b);
      offer(op, b, 1'b0, '0);
    end
    drain();
    repeat (4) @(posedge clk);

    $display("%0d items in: %0d register writes, %0d ticks", n_writes + n_ticks,
             n_writes, n_ticks);
    $display("%0d mix levels checked, spanning %0d to %0d, %0d errors", n_levels,
             lo_level, hi_level, errors);
    if (errors == 0 && level_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
